// ----- rtl/core/oamo_pkg.sv -----
`default_nettype none

package oamo_pkg;

    // Field widths fixed by the interface
    localparam int SPEED_W    = 8;
    localparam int DIR_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    // Mode request codes
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;

    // Wheel direction codes
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_A_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_B_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_A_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_B_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED  = 3'd5;

    // Configuration register reset values
    localparam logic [CFG_DATA_W-1:0] THR_RESET  = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] HYST_RESET = 12'd100;
    localparam logic [SPEED_W-1:0]    SPIN_RESET = 8'd64;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] front_a_thr;
        logic [CFG_DATA_W-1:0] front_b_thr;
        logic [CFG_DATA_W-1:0] rear_a_thr;
        logic [CFG_DATA_W-1:0] rear_b_thr;
        logic [CFG_DATA_W-1:0] hyst_offset;
        logic [SPEED_W-1:0]    spin_speed;
    } cfg_t;

    // Decision of one sensor pair check
    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_RESUME  = 3'd1,
        ACT_SPIN_BF = 3'd2,  // right backward, left forward, arms sensor b
        ACT_SPIN_FB = 3'd3,  // right forward, left backward, arms sensor a
        ACT_STOP    = 3'd4
    } pair_act_t;

endpackage

`default_nettype wire

// ----- rtl/core/oamo_cfg_regs.sv -----
`default_nettype none

module oamo_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [oamo_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [oamo_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output oamo_pkg::cfg_t                       cfg
);
    import oamo_pkg::*;

    cfg_t cfg_reg;

    // Register file: writes outside the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.front_a_thr <= THR_RESET;
            cfg_reg.front_b_thr <= THR_RESET;
            cfg_reg.rear_a_thr  <= THR_RESET;
            cfg_reg.rear_b_thr  <= THR_RESET;
            cfg_reg.hyst_offset <= HYST_RESET;
            cfg_reg.spin_speed  <= SPIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FRONT_A_THR: cfg_reg.front_a_thr <= cfg_wr_data;
                CFG_FRONT_B_THR: cfg_reg.front_b_thr <= cfg_wr_data;
                CFG_REAR_A_THR:  cfg_reg.rear_a_thr  <= cfg_wr_data;
                CFG_REAR_B_THR:  cfg_reg.rear_b_thr  <= cfg_wr_data;
                CFG_HYST_OFFSET: cfg_reg.hyst_offset <= cfg_wr_data;
                CFG_SPIN_SPEED:  cfg_reg.spin_speed  <= cfg_wr_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/oamo_pair_check.sv -----
`default_nettype none

module oamo_pair_check #(
    parameter int DIST_WIDTH = 12
) (
    input  wire logic [DIST_WIDTH-1:0] dist_a,
    input  wire logic [DIST_WIDTH-1:0] dist_b,
    input  wire logic [DIST_WIDTH-1:0] thr_a,
    input  wire logic [DIST_WIDTH-1:0] thr_b,
    input  wire logic [DIST_WIDTH-1:0] hyst_offset,
    input  wire logic                  armed_a,
    input  wire logic                  armed_b,
    output oamo_pkg::pair_act_t        act
);
    import oamo_pkg::*;

    localparam int LIM_W = DIST_WIDTH + 2;

    logic signed [LIM_W-1:0] lim_a, lim_b, da_s, db_s;
    logic                    clear_a, clear_b;

    // Resume limit: threshold less the offset when armed, compared signed
    always_comb begin
        lim_a   = $signed({2'b00, thr_a}) -
                  $signed({2'b00, (armed_a ? hyst_offset : {DIST_WIDTH{1'b0}})});
        lim_b   = $signed({2'b00, thr_b}) -
                  $signed({2'b00, (armed_b ? hyst_offset : {DIST_WIDTH{1'b0}})});
        da_s    = $signed({2'b00, dist_a});
        db_s    = $signed({2'b00, dist_b});
        clear_a = da_s < lim_a;
        clear_b = db_s < lim_b;
    end

    // Priority of the branches; equal readings fall through to hold
    always_comb begin
        if (clear_a && clear_b)
            act = ACT_RESUME;
        else if (dist_a < thr_a && dist_b > thr_b)
            act = ACT_SPIN_BF;
        else if (dist_a > thr_a && dist_b < thr_b)
            act = ACT_SPIN_FB;
        else if (dist_a > thr_a && dist_b > thr_b)
            act = ACT_STOP;
        else
            act = ACT_HOLD;
    end

endmodule

`default_nettype wire

// ----- rtl/core/obstacle_avoid_motor_override.sv -----
// An accepted input beat passes the input register, then the result register, to m_.
// One beat per cycle while m_tready stays high; the input register and the result
// register each hold one beat, and all decisions sit between them.
// Reset (aresetn low, synchronous): both stages empty, block asleep,
// hysteresis disarmed, drive outputs zero/forward, config at defaults.
`default_nettype none

module obstacle_avoid_motor_override #(
    parameter int DIST_WIDTH = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata, from bit 0: mode_request, want_speed_right, want_speed_left,
    // want_dir_right, want_dir_left, front_a_dist, front_b_dist,
    // rear_a_dist, rear_b_dist, zero padding
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [((22+4*DIST_WIDTH+7)/8)*8-1:0] s_tdata,
    // m_tdata, from bit 0: drive_speed_right, drive_speed_left,
    // drive_dir_right, drive_dir_left, zero padding
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [oamo_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [oamo_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import oamo_pkg::*;

    // Field offsets in s_tdata
    localparam int OFS_WSR = MODE_W;
    localparam int OFS_WSL = OFS_WSR + SPEED_W;
    localparam int OFS_WDR = OFS_WSL + SPEED_W;
    localparam int OFS_WDL = OFS_WDR + DIR_W;
    localparam int OFS_FA  = OFS_WDL + DIR_W;
    localparam int OFS_FB  = OFS_FA + DIST_WIDTH;
    localparam int OFS_RA  = OFS_FB + DIST_WIDTH;
    localparam int OFS_RB  = OFS_RA + DIST_WIDTH;

    // Hysteresis bit indexes
    localparam int ARM_FA = 0;
    localparam int ARM_FB = 1;
    localparam int ARM_RA = 2;
    localparam int ARM_RB = 3;

    cfg_t cfg;

    // Input stage
    logic                  in_valid_reg;
    logic [MODE_W-1:0]     in_mode_reg;
    logic [SPEED_W-1:0]    in_wsr_reg, in_wsl_reg;
    logic [DIR_W-1:0]      in_wdr_reg, in_wdl_reg;
    logic [DIST_WIDTH-1:0] in_fa_reg, in_fb_reg, in_ra_reg, in_rb_reg;

    // Block state; the held drive values are also the result payload
    logic                  out_valid_reg, out_valid_next;
    logic                  active_reg, active_next;
    logic [3:0]            armed_reg, armed_next;
    logic [SPEED_W-1:0]    spd_r_reg, spd_r_next, spd_l_reg, spd_l_next;
    logic [DIR_W-1:0]      dir_r_reg, dir_r_next, dir_l_reg, dir_l_next;

    logic                  adv;
    pair_act_t             front_act, rear_act, sel_act;
    logic                  use_pair, rear_sel;
    logic [DIST_WIDTH-1:0] hyst_w;

    oamo_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign hyst_w = DIST_WIDTH'(cfg.hyst_offset);

    oamo_pair_check #(.DIST_WIDTH(DIST_WIDTH)) u_front (
        .dist_a      (in_fa_reg),
        .dist_b      (in_fb_reg),
        .thr_a       (DIST_WIDTH'(cfg.front_a_thr)),
        .thr_b       (DIST_WIDTH'(cfg.front_b_thr)),
        .hyst_offset (hyst_w),
        .armed_a     (armed_reg[ARM_FA]),
        .armed_b     (armed_reg[ARM_FB]),
        .act         (front_act)
    );

    oamo_pair_check #(.DIST_WIDTH(DIST_WIDTH)) u_rear (
        .dist_a      (in_ra_reg),
        .dist_b      (in_rb_reg),
        .thr_a       (DIST_WIDTH'(cfg.rear_a_thr)),
        .thr_b       (DIST_WIDTH'(cfg.rear_b_thr)),
        .hyst_offset (hyst_w),
        .armed_a     (armed_reg[ARM_RA]),
        .armed_b     (armed_reg[ARM_RB]),
        .act         (rear_act)
    );

    // Handshake: the input stage moves on when the result register frees up
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, dir_l_reg, dir_r_reg, spd_l_reg, spd_r_reg};

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tdata[MODE_W-1:0];
            in_wsr_reg  <= s_tdata[OFS_WSR +: SPEED_W];
            in_wsl_reg  <= s_tdata[OFS_WSL +: SPEED_W];
            in_wdr_reg  <= s_tdata[OFS_WDR +: DIR_W];
            in_wdl_reg  <= s_tdata[OFS_WDL +: DIR_W];
            in_fa_reg   <= s_tdata[OFS_FA +: DIST_WIDTH];
            in_fb_reg   <= s_tdata[OFS_FB +: DIST_WIDTH];
            in_ra_reg   <= s_tdata[OFS_RA +: DIST_WIDTH];
            in_rb_reg   <= s_tdata[OFS_RB +: DIST_WIDTH];
        end
    end

    // Pick the checked pair from the requested directions
    always_comb begin
        use_pair = 1'b0;
        rear_sel = 1'b0;
        if (in_wdr_reg == DIR_FWD && in_wdl_reg == DIR_FWD) begin
            use_pair = 1'b1;
        end else if (in_wdr_reg == DIR_BACK && in_wdl_reg == DIR_BACK) begin
            use_pair = 1'b1;
            rear_sel = 1'b1;
        end
        sel_act = rear_sel ? rear_act : front_act;
    end

    // Next state for the item in the input stage
    always_comb begin
        active_next    = active_reg;
        armed_next     = armed_reg;
        spd_r_next     = spd_r_reg;
        spd_l_next     = spd_l_reg;
        dir_r_next     = dir_r_reg;
        dir_l_next     = dir_l_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (adv) begin
            out_valid_next = 1'b1;
            if (!active_reg) begin
                // asleep: pass through, or wake and hold
                if (in_mode_reg == MODE_ACTIVE) begin
                    active_next = 1'b1;
                end else begin
                    spd_r_next = in_wsr_reg;
                    spd_l_next = in_wsl_reg;
                    dir_r_next = in_wdr_reg;
                    dir_l_next = in_wdl_reg;
                end
            end else begin
                if (in_mode_reg == MODE_SLEEP)
                    active_next = 1'b0;
                if (!use_pair) begin
                    spd_r_next = in_wsr_reg;
                    spd_l_next = in_wsl_reg;
                    dir_r_next = in_wdr_reg;
                    dir_l_next = in_wdl_reg;
                end else begin
                    case (sel_act)
                        ACT_RESUME: begin
                            spd_r_next = in_wsr_reg;
                            spd_l_next = in_wsl_reg;
                            dir_r_next = in_wdr_reg;
                            dir_l_next = in_wdl_reg;
                            if (rear_sel) begin
                                armed_next[ARM_RA] = 1'b0;
                                armed_next[ARM_RB] = 1'b0;
                            end else begin
                                armed_next[ARM_FA] = 1'b0;
                                armed_next[ARM_FB] = 1'b0;
                            end
                        end
                        ACT_SPIN_BF: begin
                            spd_r_next = cfg.spin_speed;
                            spd_l_next = cfg.spin_speed;
                            dir_r_next = DIR_BACK;
                            dir_l_next = DIR_FWD;
                            if (rear_sel)
                                armed_next[ARM_RB] = 1'b1;
                            else
                                armed_next[ARM_FB] = 1'b1;
                        end
                        ACT_SPIN_FB: begin
                            spd_r_next = cfg.spin_speed;
                            spd_l_next = cfg.spin_speed;
                            dir_r_next = DIR_FWD;
                            dir_l_next = DIR_BACK;
                            if (rear_sel)
                                armed_next[ARM_RA] = 1'b1;
                            else
                                armed_next[ARM_FA] = 1'b1;
                        end
                        ACT_STOP: begin
                            spd_r_next = '0;
                            spd_l_next = '0;
                            dir_r_next = DIR_BACK;
                            dir_l_next = DIR_BACK;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            armed_reg     <= '0;
            spd_r_reg     <= '0;
            spd_l_reg     <= '0;
            dir_r_reg     <= DIR_FWD;
            dir_l_reg     <= DIR_FWD;
        end else begin
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            armed_reg     <= armed_next;
            spd_r_reg     <= spd_r_next;
            spd_l_reg     <= spd_l_next;
            dir_r_reg     <= dir_r_next;
            dir_l_reg     <= dir_l_next;
        end
    end

    // Drive values and hysteresis change only when an item moves through
    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(m_tdata) && $stable(armed_reg) && $stable(active_reg))
        else $error("state changed without an item");

    // Asleep and not woken: the request goes straight to the drive
    a_sleep_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !active_reg && in_mode_reg != MODE_ACTIVE |=>
            spd_r_reg == $past(in_wsr_reg) && spd_l_reg == $past(in_wsl_reg) &&
            dir_r_reg == $past(in_wdr_reg) && dir_l_reg == $past(in_wdl_reg))
        else $error("sleep pass-through broken");

    // A stop never touches the hysteresis
    a_stop_keeps_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && active_reg && use_pair && sel_act == ACT_STOP |=>
            armed_reg == $past(armed_reg))
        else $error("stop changed hysteresis");

    // Hysteresis is only touched while active
    a_arm_only_active: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !active_reg |=> armed_reg == $past(armed_reg))
        else $error("hysteresis changed while asleep");

endmodule

`default_nettype wire

// ----- verif/oamo_drive_checker.sv -----
module oamo_drive_checker #(
    parameter int DIST_WIDTH = 12
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    input  wire logic                                  s_tready,
    // s_tdata, from bit 0: mode_request, want_speed_right, want_speed_left,
    // want_dir_right, want_dir_left, front_a_dist, front_b_dist,
    // rear_a_dist, rear_b_dist, zero padding
    input  wire logic [((22+4*DIST_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  wire logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata, from bit 0: drive_speed_right, drive_speed_left,
    // drive_dir_right, drive_dir_left, zero padding
    input  wire logic [23:0]                           m_tdata,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [oamo_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  wire logic [oamo_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    output int                                         fail_count,
    output int                                         pending,
    output int                                         items_seen,
    output int                                         results_seen,
    output int                                         resume_count,
    output int                                         spin_count,
    output int                                         stop_count,
    output int                                         hold_count
);
    import oamo_pkg::*;

    localparam int S_W = ((22+4*DIST_WIDTH+7)/8)*8;

    // Packed so that bit 0 is the right wheel speed, matching m_tdata
    typedef struct packed {
        logic [DIR_W-1:0]   dir_l;
        logic [DIR_W-1:0]   dir_r;
        logic [SPEED_W-1:0] spd_l;
        logic [SPEED_W-1:0] spd_r;
    } drive_cmd_t;

    // Shadow of the register file
    logic [DIST_WIDTH-1:0] thr [4];
    logic [DIST_WIDTH-1:0] hyst;
    logic [SPEED_W-1:0]    spin;

    // Shadow of the block's own state
    logic       awake;
    logic       armed [4];
    drive_cmd_t held;

    drive_cmd_t expected_cmds [$];

    function automatic drive_cmd_t make_cmd(input logic [SPEED_W-1:0] sr, sl,
                                            input logic [DIR_W-1:0] dr, dl);
        drive_cmd_t c;
        c.spd_r = sr;
        c.spd_l = sl;
        c.dir_r = dr;
        c.dir_l = dl;
        return c;
    endfunction

    // Decision for one sensor pair; the resume limit is a signed quantity
    function automatic pair_act_t pair_decision(input logic [DIST_WIDTH-1:0] da, db, ta, tb,
                                                input logic arm_a, arm_b);
        int lim_a;
        int lim_b;
        lim_a = int'(ta) - (arm_a ? int'(hyst) : 0);
        lim_b = int'(tb) - (arm_b ? int'(hyst) : 0);
        if (int'(da) < lim_a && int'(db) < lim_b)
            return ACT_RESUME;
        else if (da < ta && db > tb)
            return ACT_SPIN_BF;
        else if (da > ta && db < tb)
            return ACT_SPIN_FB;
        else if (da > ta && db > tb)
            return ACT_STOP;
        return ACT_HOLD;
    endfunction

    task automatic update_pair(input logic [DIST_WIDTH-1:0] da, db, ta, tb,
                               input int ka, kb, input drive_cmd_t want);
        pair_act_t act;
        act = pair_decision(da, db, ta, tb, armed[ka], armed[kb]);
        case (act)
            ACT_RESUME: begin
                held = want;
                armed[ka] = 1'b0;
                armed[kb] = 1'b0;
                resume_count++;
            end
            ACT_SPIN_BF: begin
                held = make_cmd(spin, spin, DIR_BACK, DIR_FWD);
                armed[kb] = 1'b1;
                spin_count++;
            end
            ACT_SPIN_FB: begin
                held = make_cmd(spin, spin, DIR_FWD, DIR_BACK);
                armed[ka] = 1'b1;
                spin_count++;
            end
            ACT_STOP: begin
                held = make_cmd('0, '0, DIR_BACK, DIR_BACK);
                stop_count++;
            end
            default: hold_count++;
        endcase
    endtask

    // Works out the drive command for one accepted input beat
    task automatic next_drive_cmd(input logic [S_W-1:0] beat);
        logic [MODE_W-1:0]     mode;
        drive_cmd_t            want;
        logic [DIST_WIDTH-1:0] fa, fb, ra, rb;
        mode = beat[1:0];
        want = make_cmd(beat[9:2], beat[17:10], beat[19:18], beat[21:20]);
        fa   = beat[22 +: DIST_WIDTH];
        fb   = beat[22 + DIST_WIDTH +: DIST_WIDTH];
        ra   = beat[22 + 2*DIST_WIDTH +: DIST_WIDTH];
        rb   = beat[22 + 3*DIST_WIDTH +: DIST_WIDTH];
        if (!awake) begin
            // asleep: pass through, or wake and hold
            if (mode == MODE_ACTIVE)
                awake = 1'b1;
            else
                held = want;
        end else begin
            // a sleep request still lets this beat's checks run
            if (mode == MODE_SLEEP)
                awake = 1'b0;
            if (want.dir_r == DIR_FWD && want.dir_l == DIR_FWD)
                update_pair(fa, fb, thr[0], thr[1], 0, 1, want);
            else if (want.dir_r == DIR_BACK && want.dir_l == DIR_BACK)
                update_pair(ra, rb, thr[2], thr[3], 2, 3, want);
            else
                held = want;
        end
        expected_cmds.push_back(held);
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        fail_count++;
        $display("MISMATCH result %0d %s: expected %0d, got %0d",
                 results_seen, what, exp_v, got_v);
    endtask

    // Watch both channels and the register port
    always @(posedge aclk) begin
        drive_cmd_t got;
        drive_cmd_t exp_cmd;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                thr[i]   = DIST_WIDTH'(THR_RESET);
                armed[i] = 1'b0;
            end
            hyst  = DIST_WIDTH'(HYST_RESET);
            spin  = SPIN_RESET;
            awake = 1'b0;
            held  = '0;
            expected_cmds.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_FRONT_A_THR: thr[0] = DIST_WIDTH'(cfg_wr_data);
                    CFG_FRONT_B_THR: thr[1] = DIST_WIDTH'(cfg_wr_data);
                    CFG_REAR_A_THR:  thr[2] = DIST_WIDTH'(cfg_wr_data);
                    CFG_REAR_B_THR:  thr[3] = DIST_WIDTH'(cfg_wr_data);
                    CFG_HYST_OFFSET: hyst   = DIST_WIDTH'(cfg_wr_data);
                    CFG_SPIN_SPEED:  spin   = cfg_wr_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[19:0];
                if (expected_cmds.size() == 0) begin
                    report_mismatch("beat with nothing expected", -1, int'(m_tdata));
                end else begin
                    exp_cmd = expected_cmds.pop_front();
                    if (got.spd_r !== exp_cmd.spd_r)
                        report_mismatch("drive_speed_right", int'(exp_cmd.spd_r),
                                        int'(got.spd_r));
                    if (got.spd_l !== exp_cmd.spd_l)
                        report_mismatch("drive_speed_left", int'(exp_cmd.spd_l),
                                        int'(got.spd_l));
                    if (got.dir_r !== exp_cmd.dir_r)
                        report_mismatch("drive_dir_right", int'(exp_cmd.dir_r),
                                        int'(got.dir_r));
                    if (got.dir_l !== exp_cmd.dir_l)
                        report_mismatch("drive_dir_left", int'(exp_cmd.dir_l),
                                        int'(got.dir_l));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                next_drive_cmd(s_tdata);
                items_seen++;
            end
        end
        pending = expected_cmds.size();
    end

endmodule

// ----- verif/obstacle_avoid_motor_override_test.sv -----
module obstacle_avoid_motor_override_test;
    import oamo_pkg::*;

    localparam int DIST_WIDTH = 12;
    localparam int S_W        = ((22+4*DIST_WIDTH+7)/8)*8;

    // Codes with no name in the package
    localparam logic [MODE_W-1:0] MODE_KEEP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE3 = 2'd3;
    localparam logic [DIR_W-1:0]  DIR_OTHER  = 2'd2;
    localparam logic [DIR_W-1:0]  DIR_CODE3  = 2'd3;

    localparam int LONG_STALL = 60;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic [S_W-1:0]        s_tdata      = '0;
    logic                  m_tready     = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [23:0]           m_tdata;

    int fail_count, pending, items_seen, results_seen;
    int resume_count, spin_count, stop_count, hold_count;

    // Handshake pacing
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic long_stall_req = 1'b0;
    int   stall_left     = 0;
    logic s_accept       = 1'b0;

    // Register values as last written, used to aim readings at the thresholds
    logic [11:0] thr_cfg [4];
    logic [11:0] hyst_cfg;

    obstacle_avoid_motor_override #(.DIST_WIDTH(DIST_WIDTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    oamo_drive_checker #(.DIST_WIDTH(DIST_WIDTH)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending),
        .items_seen(items_seen), .results_seen(results_seen),
        .resume_count(resume_count), .spin_count(spin_count),
        .stop_count(stop_count), .hold_count(hold_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Input beat taken at this edge; read back at the following falling edge
    always @(posedge aclk)
        s_accept <= s_tvalid && s_tready;

    // Receiver: random stalls, plus one long hold-off counted here
    always @(negedge aclk) begin
        if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [SPEED_W-1:0] sr, sl,
                             input logic [DIR_W-1:0] dr, dl,
                             input logic [11:0] fa, fb, ra, rb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, rb, ra, fb, fa, dl, dr, sl, sr, mode};
        do @(negedge aclk); while (!s_accept);
    endtask

    // Stop offering and wait for the pipeline to empty
    task automatic settle();
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_FRONT_A_THR: thr_cfg[0] = val;
            CFG_FRONT_B_THR: thr_cfg[1] = val;
            CFG_REAR_A_THR:  thr_cfg[2] = val;
            CFG_REAR_B_THR:  thr_cfg[3] = val;
            CFG_HYST_OFFSET: hyst_cfg   = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [11:0] ta, tb, tc, td, hy, input logic [7:0] sp);
        write_reg(CFG_FRONT_A_THR, ta);
        write_reg(CFG_FRONT_B_THR, tb);
        write_reg(CFG_REAR_A_THR, tc);
        write_reg(CFG_REAR_B_THR, td);
        write_reg(CFG_HYST_OFFSET, hy);
        write_reg(CFG_SPIN_SPEED, {4'd0, sp});
    endtask

    // Reading aimed around a threshold, its hysteresis point, or anywhere
    function automatic logic [11:0] near(input logic [11:0] thr);
        int v;
        case ($urandom_range(9))
            0, 1:    v = int'(thr);
            2, 3:    v = int'(thr) + int'($urandom_range(1, 40));
            4, 5:    v = int'(thr) - int'($urandom_range(1, 40));
            6:       v = int'(thr) - int'(hyst_cfg) + int'($urandom_range(0, 8)) - 4;
            7:       v = int'($urandom_range(4095));
            default: v = $urandom_range(1) ? 0 : 4095;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // Mostly awake, mostly straight motion, readings close to the thresholds
    task automatic random_beat();
        logic [MODE_W-1:0] mode;
        logic [DIR_W-1:0]  dr, dl;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 6)
            mode = MODE_SLEEP;
        else if (pick < 14)
            mode = MODE_ACTIVE;
        else if (pick < 18)
            mode = MODE_CODE3;
        else
            mode = MODE_KEEP;
        pick = $urandom_range(99);
        if (pick < 45) begin
            dr = DIR_FWD;
            dl = DIR_FWD;
        end else if (pick < 90) begin
            dr = DIR_BACK;
            dl = DIR_BACK;
        end else begin
            dr = DIR_W'($urandom_range(3));
            dl = DIR_W'($urandom_range(3));
        end
        send_beat(mode, SPEED_W'($urandom_range(255)), SPEED_W'($urandom_range(255)), dr, dl,
                  near(thr_cfg[0]), near(thr_cfg[1]), near(thr_cfg[2]), near(thr_cfg[3]));
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed beats at the default settings
        load_regs(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd100, 8'd64);
        send_beat(MODE_SLEEP, 8'd255, 8'd0, DIR_BACK, DIR_OTHER, 0, 0, 0, 0);
        send_beat(MODE_KEEP, 8'd0, 8'd255, DIR_CODE3, DIR_FWD, 4095, 4095, 4095, 4095);
        send_beat(MODE_CODE3, 8'd170, 8'd85, DIR_FWD, DIR_BACK, 1000, 3000, 0, 4095);
        send_beat(MODE_ACTIVE, 8'd12, 8'd34, DIR_FWD, DIR_FWD, 100, 100, 100, 100);
        send_beat(MODE_KEEP, 8'd100, 8'd101, DIR_FWD, DIR_FWD, 100, 100, 4095, 4095);
        send_beat(MODE_KEEP, 8'd100, 8'd101, DIR_FWD, DIR_FWD, 100, 3000, 0, 0);
        // armed sensor b: 2000 is below the threshold but not below the lowered one
        send_beat(MODE_KEEP, 8'd50, 8'd60, DIR_FWD, DIR_FWD, 100, 2000, 0, 0);
        send_beat(MODE_KEEP, 8'd50, 8'd60, DIR_FWD, DIR_FWD, 100, 1900, 0, 0);
        send_beat(MODE_KEEP, 8'd1, 8'd2, DIR_FWD, DIR_FWD, 3000, 100, 0, 0);
        send_beat(MODE_KEEP, 8'd1, 8'd2, DIR_FWD, DIR_FWD, 4095, 4095, 0, 0);
        // reading equal to its threshold: nothing matches, outputs held
        send_beat(MODE_KEEP, 8'd7, 8'd8, DIR_FWD, DIR_FWD, 2048, 2048, 0, 0);
        send_beat(MODE_KEEP, 8'd9, 8'd10, DIR_BACK, DIR_BACK, 0, 0, 3000, 100);
        send_beat(MODE_KEEP, 8'd9, 8'd10, DIR_BACK, DIR_BACK, 0, 0, 100, 3000);
        send_beat(MODE_KEEP, 8'd9, 8'd10, DIR_BACK, DIR_BACK, 0, 0, 1990, 1990);
        send_beat(MODE_KEEP, 8'd200, 8'd201, DIR_BACK, DIR_BACK, 4095, 4095, 0, 0);
        send_beat(MODE_KEEP, 8'd200, 8'd201, DIR_BACK, DIR_BACK, 0, 0, 4095, 4095);
        send_beat(MODE_CODE3, 8'd33, 8'd44, DIR_FWD, DIR_BACK, 4095, 4095, 4095, 4095);
        send_beat(MODE_KEEP, 8'd55, 8'd66, DIR_OTHER, DIR_CODE3, 0, 0, 0, 0);
        // sleep request while awake: checks still apply on this beat
        send_beat(MODE_SLEEP, 8'd77, 8'd88, DIR_FWD, DIR_FWD, 4095, 4095, 0, 0);
        send_beat(MODE_KEEP, 8'd255, 8'd255, DIR_CODE3, DIR_CODE3, 0, 0, 0, 0);
        send_beat(MODE_ACTIVE, 8'd0, 8'd0, DIR_BACK, DIR_BACK, 0, 0, 0, 0);

        // Long receiver hold-off while beats keep coming, to back up the input
        @(posedge aclk);
        long_stall_req = 1'b1;
        @(negedge aclk);
        repeat (12) random_beat();

        // Random beats over several register settings and handshake mixes
        for (int setting = 0; setting < 5; setting++) begin
            settle();
            case (setting)
                0: load_regs(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd100, 8'd64);
                1: load_regs(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
                2: load_regs(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255);
                3: load_regs(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                             12'($urandom_range(4095)), 12'($urandom_range(4095)),
                             12'($urandom_range(600)), 8'($urandom_range(255)));
                // offset above the thresholds: lowered limits go negative
                default: load_regs(12'($urandom_range(300)), 12'($urandom_range(300)),
                                   12'($urandom_range(300)), 12'($urandom_range(300)),
                                   12'($urandom_range(2000, 4095)),
                                   8'($urandom_range(255)));
            endcase
            for (int mix = 0; mix < 4; mix++) begin
                case (mix)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                    default: begin send_idle_pct = 8; recv_stall_pct = 8; end
                endcase
                repeat (95) random_beat();
            end
        end

        settle();
        repeat (8) @(negedge aclk);
        $display("Run covered %0d input beats and %0d drive commands over five register sets.",
                 items_seen, results_seen);
        $display("Pair decisions seen: %0d resume, %0d spin, %0d stop, %0d hold.",
                 resume_count, spin_count, stop_count, hold_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
